@@ rtl/mhd_pkg.sv @@
`default_nettype none

package mhd_pkg;

  // Frame shape
  localparam int CHANNELS     = 4;
  localparam int SAMPLE_BITS  = 16;
  localparam int DELAY_DEPTH  = 4096;
  localparam int ADDR_BITS    = $clog2(DELAY_DEPTH);
  localparam int LEN_BITS     = 12;
  localparam int CMP_BITS     = ((LEN_BITS > ADDR_BITS) ? LEN_BITS : ADDR_BITS) + 1;

  // Mixing arithmetic
  localparam int COEF_BITS    = 16;
  localparam int COEF_FRAC    = 14;
  localparam int DELAYED_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS    = COEF_BITS + DELAYED_BITS;
  localparam int ACC_BITS     = PROD_BITS + $clog2(CHANNELS);

  // Queue between front and back
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = QPTR_BITS + 1;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = CHANNELS * COEF_BITS;

  localparam logic [CHANNELS*LEN_BITS-1:0] LENGTHS_RESET = 48'h001001001001;
  localparam logic [COEF_BITS-1:0]         COEF_ONE      = 16'h4000;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DELAY_LENGTHS = 3'd0,
    REG_POLARITY_MASK = 3'd1,
    REG_MIX_ROW_0     = 3'd2,
    REG_MIX_ROW_1     = 3'd3,
    REG_MIX_ROW_2     = 3'd4,
    REG_MIX_ROW_3     = 3'd5
  } reg_index_t;

  typedef logic [CHANNELS-1:0][DELAYED_BITS-1:0]          tap_vec_t;
  typedef logic [CHANNELS-1:0][CHANNELS-1:0][COEF_BITS-1:0] mix_matrix_t;

  typedef struct packed {
    logic [CHANNELS-1:0][LEN_BITS-1:0] lengths;
    logic [CHANNELS-1:0]               polarity;
  } front_cfg_t;

endpackage

`default_nettype wire

@@ rtl/mhd_if.sv @@
`default_nettype none

interface mhd_frame_if import mhd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_0;
  logic signed [SAMPLE_BITS-1:0] sample_1;
  logic signed [SAMPLE_BITS-1:0] sample_2;
  logic signed [SAMPLE_BITS-1:0] sample_3;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3, input ready);
  modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, output ready);
endinterface

interface mhd_mix_if import mhd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mixed_0;
  logic signed [SAMPLE_BITS-1:0] mixed_1;
  logic signed [SAMPLE_BITS-1:0] mixed_2;
  logic signed [SAMPLE_BITS-1:0] mixed_3;

  modport source (output valid, mixed_0, mixed_1, mixed_2, mixed_3, input ready);
  modport sink   (input valid, mixed_0, mixed_1, mixed_2, mixed_3, output ready);
endinterface

`default_nettype wire

@@ rtl/multichannel_delay_householder_diffuser.sv @@
// Channel   | Dir | Handshake                  | Payload
// samples   | in  | valid/ready, interface     | sample_0..sample_3, signed 16 bit
// mixed     | out | valid/ready, interface     | mixed_0..mixed_3, signed 16 bit
// cfg       | in  | cfg_write, no wait         | cfg_index 3 bit, cfg_data 64 bit
//
// One frame per cycle sustained while mixed.ready holds high; output stalls can drop samples.ready.
// A result passes the registered delay-memory read, the queue slot and the product
// stage into the output register; the row sums feed the output register directly.
// After reset the delay memories are swept to zero, all 4096 entries; samples.ready stays
// low during the sweep, while configuration writes are taken as usual.
// A four-entry queue between the memory side and the mixer absorbs output stalls.
`default_nettype none

module multichannel_delay_householder_diffuser import mhd_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  mhd_frame_if.sink                      samples,
  mhd_mix_if.source                      mixed,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [CHANNELS*LEN_BITS-1:0] delay_lengths;
  logic [CHANNELS-1:0]          polarity_mask;
  mix_matrix_t                  matrix;
  front_cfg_t                   front_cfg;

  logic                 push;
  tap_vec_t             push_data;
  logic                 pop;
  logic                 head_valid;
  tap_vec_t             head_data;
  logic [QCNT_BITS-1:0] queue_count;

  // Decode register writes; unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_lengths <= LENGTHS_RESET;
      polarity_mask <= '0;
      for (int r = 0; r < CHANNELS; r++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          matrix[r][c] <= (r == c) ? COEF_ONE : '0;
        end
      end
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_DELAY_LENGTHS: delay_lengths <= cfg_data[CHANNELS*LEN_BITS-1:0];
        REG_POLARITY_MASK: polarity_mask <= cfg_data[CHANNELS-1:0];
        REG_MIX_ROW_0:     matrix[0] <= cfg_data;
        REG_MIX_ROW_1:     matrix[1] <= cfg_data;
        REG_MIX_ROW_2:     matrix[2] <= cfg_data;
        REG_MIX_ROW_3:     matrix[3] <= cfg_data;
        default:           ;
      endcase
    end
  end

  assign front_cfg.lengths  = delay_lengths;
  assign front_cfg.polarity = polarity_mask;

  mhd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .cfg         (front_cfg),
    .queue_count (queue_count),
    .push        (push),
    .push_data   (push_data)
  );

  mhd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (queue_count)
  );

  mhd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .matrix     (matrix),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .mixed      (mixed)
  );

endmodule

`default_nettype wire

@@ rtl/mhd_front.sv @@
`default_nettype none

module mhd_front import mhd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  mhd_frame_if.sink             samples,
  input  wire front_cfg_t       cfg,
  input  wire logic [QCNT_BITS-1:0] queue_count,
  output logic                  push,
  output tap_vec_t              push_data
);

  logic                                 clr_active;
  logic [ADDR_BITS-1:0]                 clr_addr;
  logic                                 rd_valid;
  logic                                 accept;
  logic                                 mem_we;
  logic [CHANNELS-1:0][ADDR_BITS-1:0]   wpos;
  logic [CHANNELS-1:0][ADDR_BITS-1:0]   wpos_next;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_vec;

  assign sample_vec = {samples.sample_3, samples.sample_2, samples.sample_1, samples.sample_0};

  // Take a frame only when the queue can hold it and the one still in the memory read
  assign samples.ready = !clr_active &&
                         ((queue_count + QCNT_BITS'(rd_valid)) < QCNT_BITS'(QUEUE_DEPTH));
  assign accept = samples.valid && samples.ready;
  assign mem_we = accept || clr_active;

  // Sweep the delay memories to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_BITS'(DELAY_DEPTH - 1)) clr_active <= 1'b0;
    end
  end

  // Advance each write position, wrapping at the clamped length
  always_comb begin
    logic [CMP_BITS-1:0] len;
    logic [CMP_BITS-1:0] nxt;
    for (int c = 0; c < CHANNELS; c++) begin
      len = CMP_BITS'(cfg.lengths[c]);
      if (len == '0) len = CMP_BITS'(1);
      if (len > CMP_BITS'(DELAY_DEPTH)) len = CMP_BITS'(DELAY_DEPTH);
      nxt = CMP_BITS'(wpos[c]) + CMP_BITS'(1);
      wpos_next[c] = (nxt >= len) ? '0 : nxt[ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos     <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= accept;
      if (accept) wpos <= wpos_next;
    end
  end

  // One delay memory per channel, read before write at the same slot
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic [SAMPLE_BITS-1:0]  mem [DELAY_DEPTH];
    logic [SAMPLE_BITS-1:0]  rdata;
    logic [ADDR_BITS-1:0]    waddr;
    logic [SAMPLE_BITS-1:0]  wdata;
    logic [DELAYED_BITS-1:0] ext;

    assign waddr = clr_active ? clr_addr : wpos[c];
    assign wdata = clr_active ? '0 : sample_vec[c];

    always_ff @(posedge clk) begin
      if (mem_we) mem[waddr] <= wdata;
      rdata <= mem[wpos[c]];
    end

    // Negate at full width so the most negative sample does not wrap
    assign ext          = {rdata[SAMPLE_BITS-1], rdata};
    assign push_data[c] = cfg.polarity[c] ? (DELAYED_BITS'(0) - ext) : ext;
  end

  assign push = rd_valid;

endmodule

`default_nettype wire

@@ rtl/mhd_queue.sv @@
`default_nettype none

module mhd_queue import mhd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire tap_vec_t push_data,
  input  wire logic     pop,
  output logic          head_valid,
  output tap_vec_t      head_data,
  output logic [QCNT_BITS-1:0] count
);

  tap_vec_t             slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;

  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  // Store on push; the front never pushes into a full queue
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/mhd_back.sv @@
`default_nettype none

module mhd_back import mhd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire mix_matrix_t matrix,
  input  wire logic        head_valid,
  input  wire tap_vec_t    head_data,
  output logic             pop,
  mhd_mix_if.source        mixed
);

  localparam int Y_BITS = ACC_BITS - COEF_FRAC;
  localparam logic signed [Y_BITS-1:0]   Y_MAX = Y_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Y_BITS-1:0]   Y_MIN = -Y_BITS'(2 ** (SAMPLE_BITS - 1));
  localparam logic signed [ACC_BITS-1:0] ROUND_BIAS = ACC_BITS'(2 ** (COEF_FRAC - 1));

  logic                          prod_valid;
  logic signed [PROD_BITS-1:0]   prod [CHANNELS][CHANNELS];
  logic                          out_valid;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] out_data;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] mix_next;
  logic                          out_load;
  logic                          prod_load;

  // The output register loads when empty or when its transfer completes
  assign out_load  = !out_valid || mixed.ready;
  assign prod_load = !prod_valid || out_load;
  assign pop       = head_valid && prod_load;

  // Stage one: all coefficient products
  always_ff @(posedge clk) begin
    if (prod_load) begin
      for (int r = 0; r < CHANNELS; r++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          prod[r][c] <= $signed(matrix[r][c]) * $signed(head_data[c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_load) begin
      prod_valid <= head_valid;
    end
  end

  // Stage two: sum each row, round half up, saturate
  always_comb begin
    logic signed [ACC_BITS-1:0] acc;
    logic signed [Y_BITS-1:0]   y;
    for (int r = 0; r < CHANNELS; r++) begin
      acc = ROUND_BIAS;
      for (int c = 0; c < CHANNELS; c++) begin
        acc = acc + {{(ACC_BITS - PROD_BITS){prod[r][c][PROD_BITS-1]}}, prod[r][c]};
      end
      y = acc[ACC_BITS-1:COEF_FRAC];
      priority if (y > Y_MAX) mix_next[r] = Y_MAX[SAMPLE_BITS-1:0];
      else if (y < Y_MIN)     mix_next[r] = Y_MIN[SAMPLE_BITS-1:0];
      else                    mix_next[r] = y[SAMPLE_BITS-1:0];
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (out_load) out_data <= mix_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= prod_valid;
    end
  end

  assign mixed.valid   = out_valid;
  assign mixed.mixed_0 = out_data[0];
  assign mixed.mixed_1 = out_data[1];
  assign mixed.mixed_2 = out_data[2];
  assign mixed.mixed_3 = out_data[3];

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`default_nettype none

module tb_top;
  import mhd_pkg::*;

  localparam int CYCLE_LIMIT      = 600000;
  localparam int REPORT_LIMIT     = 10;
  localparam int RANDOM_PHASES    = 7;
  localparam int FRAMES_PER_PHASE = 150;
  localparam int LAST_LEN         = (1 << LEN_BITS) - 1;
  localparam int ROW_BITS         = $clog2(CHANNELS);

  // Indexes that decode to no register
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [COEF_BITS-1:0] COEF_HALF     = 16'h2000;
  localparam logic [COEF_BITS-1:0] COEF_NEG_HALF = 16'hE000;
  localparam logic [COEF_BITS-1:0] COEF_MAX      = 16'h7FFF;
  localparam logic [COEF_BITS-1:0] COEF_MIN      = 16'h8000;

  localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) << (SAMPLE_BITS - 1));

  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] frame_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  mhd_frame_if frame_bus();
  mhd_mix_if   mix_bus();

  multichannel_delay_householder_diffuser dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (frame_bus),
    .mixed     (mix_bus),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block's settings and delay lines
  logic [CHANNELS*LEN_BITS-1:0]  lengths_reg;
  logic [CHANNELS-1:0]           polarity_reg;
  logic [CFG_DATA_BITS-1:0]      mix_rows [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] delay_mem [CHANNELS][DELAY_DEPTH];
  int                            tap_pos [CHANNELS];

  frame_t frame_backlog[$];
  frame_t expected_mix[$];
  frame_t staged_frame;
  frame_t mix_pred;
  frame_t mix_seen;
  frame_t mix_due;

  int mismatch_count = 0;
  int cycle_count    = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  bit quiet_run      = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Delay each channel, apply polarity, mix, round and saturate
  function automatic frame_t diffuse_frame(frame_t in_frame);
    longint tap [CHANNELS];
    longint acc;
    int     len;
    int     pos;
    frame_t result;
    for (int c = 0; c < CHANNELS; c++) begin
      len = int'(lengths_reg[c*LEN_BITS +: LEN_BITS]);
      if (len == 0) len = 1;
      if (len > DELAY_DEPTH) len = DELAY_DEPTH;
      pos = tap_pos[c] % DELAY_DEPTH;
      tap[c] = longint'(delay_mem[c][ADDR_BITS'(pos)]);
      if (polarity_reg[c]) tap[c] = -tap[c];
      delay_mem[c][ADDR_BITS'(pos)] = in_frame[c];
      pos++;
      if (pos >= len) pos = 0;
      tap_pos[c] = pos;
    end
    for (int r = 0; r < CHANNELS; r++) begin
      acc = 0;
      for (int c = 0; c < CHANNELS; c++)
        acc += longint'($signed(mix_rows[r][c*COEF_BITS +: COEF_BITS])) * tap[c];
      acc = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      result[r] = acc[SAMPLE_BITS-1:0];
    end
    return result;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return '0;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    for (int c = 0; c < CHANNELS; c++) f[c] = rand_sample();
    return f;
  endfunction

  // Householder, full-range random, moderate random, or a channel rotation
  function automatic logic [CFG_DATA_BITS-1:0] make_row(int style, int r);
    logic [CFG_DATA_BITS-1:0] row;
    for (int c = 0; c < CHANNELS; c++) begin
      case (style)
        0:       row[c*COEF_BITS +: COEF_BITS] = (c == r) ? COEF_HALF : COEF_NEG_HALF;
        1:       row[c*COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom);
        2:       row[c*COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom_range(0, 32768) - 16384);
        default: row[c*COEF_BITS +: COEF_BITS] = (c == (r + 1) % CHANNELS) ? COEF_ONE : '0;
      endcase
    end
    return row;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  // Append a frame to the stimulus backlog
  task automatic enqueue_frame(input frame_t f);
    frame_backlog = {frame_backlog, f};
  endtask

  // One register write; the shadow follows at once since the block is idle
  task automatic program_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_DELAY_LENGTHS: lengths_reg = value[CHANNELS*LEN_BITS-1:0];
      REG_POLARITY_MASK: polarity_reg = value[CHANNELS-1:0];
      REG_MIX_ROW_0, REG_MIX_ROW_1, REG_MIX_ROW_2, REG_MIX_ROW_3:
        mix_rows[ROW_BITS'(idx - REG_MIX_ROW_0)] = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_random_setting();
    logic [CHANNELS*LEN_BITS-1:0] lens;
    int style;
    style = $urandom_range(0, 3);
    for (int c = 0; c < CHANNELS; c++) begin
      case ($urandom_range(0, 19))
        0, 1:          lens[c*LEN_BITS +: LEN_BITS] = LEN_BITS'(LAST_LEN);
        2:             lens[c*LEN_BITS +: LEN_BITS] = LEN_BITS'($urandom_range(0, LAST_LEN));
        3, 4, 5, 6, 7: lens[c*LEN_BITS +: LEN_BITS] = LEN_BITS'($urandom_range(9, 64));
        default:       lens[c*LEN_BITS +: LEN_BITS] = LEN_BITS'($urandom_range(0, 8));
      endcase
    end
    program_reg(REG_DELAY_LENGTHS, CFG_DATA_BITS'(lens));
    program_reg(REG_POLARITY_MASK, CFG_DATA_BITS'($urandom_range(0, 15)));
    for (int r = 0; r < CHANNELS; r++)
      program_reg(CFG_INDEX_BITS'(int'(REG_MIX_ROW_0) + r), make_row(style, r));
  endtask

  // Hold until every frame is sent and every result is back; sample between edges
  task automatic wait_drained();
    while (frame_backlog.size() != 0 || frame_bus.valid || expected_mix.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Frame driver: predict on each transfer, then present the next frame or idle
  always @(posedge clk) begin
    if (rst) begin
      frame_bus.valid <= 1'b0;
    end else begin
      if (frame_bus.valid && frame_bus.ready) begin
        mix_pred = diffuse_frame({frame_bus.sample_3, frame_bus.sample_2,
                                  frame_bus.sample_1, frame_bus.sample_0});
        expected_mix = {expected_mix, mix_pred};
      end
      if (!frame_bus.valid || frame_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          frame_bus.valid <= 1'b0;
        end else if (frame_backlog.size() != 0) begin
          if (!quiet_run && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 12);
            frame_bus.valid <= 1'b0;
          end else begin
            staged_frame = frame_backlog.pop_front();
            frame_bus.sample_0 <= staged_frame[0];
            frame_bus.sample_1 <= staged_frame[1];
            frame_bus.sample_2 <= staged_frame[2];
            frame_bus.sample_3 <= staged_frame[3];
            frame_bus.valid    <= 1'b1;
          end
        end else begin
          frame_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      mix_bus.ready <= 1'b0;
    end else begin
      if (mix_bus.valid && mix_bus.ready) begin
        mix_seen = {mix_bus.mixed_3, mix_bus.mixed_2, mix_bus.mixed_1, mix_bus.mixed_0};
        if (expected_mix.size() == 0) begin
          flag_error($sformatf("unexpected result %h", mix_seen));
        end else begin
          mix_due = expected_mix.pop_front();
          for (int c = 0; c < CHANNELS; c++)
            if (mix_seen[c] !== mix_due[c])
              flag_error($sformatf("mixed_%0d: expected %0d, got %0d", c,
                                   $signed(mix_due[c]), $signed(mix_seen[c])));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        mix_bus.ready <= 1'b0;
      end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 12);
        mix_bus.ready <= 1'b0;
      end else begin
        mix_bus.ready <= 1'b1;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    frame_bus.valid    = 1'b0;
    frame_bus.sample_0 = '0;
    frame_bus.sample_1 = '0;
    frame_bus.sample_2 = '0;
    frame_bus.sample_3 = '0;
    mix_bus.ready      = 1'b0;

    // Shadow reset state: unit lengths, no inversion, identity matrix
    lengths_reg  = LENGTHS_RESET;
    polarity_reg = '0;
    for (int r = 0; r < CHANNELS; r++) begin
      mix_rows[r] = '0;
      mix_rows[r][r*COEF_BITS +: COEF_BITS] = COEF_ONE;
      tap_pos[r] = 0;
      for (int a = 0; a < DELAY_DEPTH; a++) delay_mem[r][a] = '0;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: sample extremes and bit patterns
    enqueue_frame(64'h7FFF_7FFF_7FFF_7FFF);
    enqueue_frame(64'h8000_8000_8000_8000);
    enqueue_frame(64'h0000_0000_0000_0000);
    enqueue_frame(64'hFFFF_FFFF_FFFF_FFFF);
    enqueue_frame(64'h0001_0001_0001_0001);
    enqueue_frame(64'hAAAA_5555_AAAA_5555);
    enqueue_frame(64'h5555_AAAA_5555_AAAA);
    enqueue_frame(64'h0000_7FFF_8000_1234);
    wait_drained();

    // Zero and longest lengths, full inversion, extreme coefficients
    program_reg(REG_DELAY_LENGTHS, 64'h0000_0030_02FF_F000);
    program_reg(REG_POLARITY_MASK, 64'hF);
    program_reg(REG_MIX_ROW_0, {CHANNELS{COEF_MAX}});
    program_reg(REG_MIX_ROW_1, {CHANNELS{COEF_MIN}});
    program_reg(REG_MIX_ROW_2, make_row(0, 2));
    program_reg(REG_MIX_ROW_3, {COEF_ONE, COEF_NEG_HALF, COEF_MIN, COEF_MAX});
    // Writes to unmapped indexes must leave the settings alone
    program_reg(REG_SPARE_LO, '1);
    program_reg(REG_SPARE_HI, '1);
    enqueue_frame(64'h8000_8000_8000_8000);
    enqueue_frame(64'h8000_8000_8000_8000);
    enqueue_frame(64'h8000_8000_8000_8000);
    enqueue_frame(64'h7FFF_7FFF_7FFF_7FFF);
    enqueue_frame(64'h7FFF_7FFF_7FFF_7FFF);
    enqueue_frame(64'h7FFF_7FFF_7FFF_7FFF);
    enqueue_frame(64'h8000_7FFF_8000_7FFF);
    enqueue_frame(64'h7FFF_8000_7FFF_8000);
    enqueue_frame(64'h0001_FFFF_0001_FFFF);
    enqueue_frame(64'h0000_0000_0000_0000);
    enqueue_frame(64'hAAAA_5555_AAAA_5555);
    enqueue_frame(64'h8000_8000_8000_8000);
    wait_drained();

    // Shorten lengths below the channel 1 write pointer; old contents read back
    program_reg(REG_DELAY_LENGTHS, 64'h0000_0020_0200_2002);
    repeat (4) enqueue_frame(rand_frame());
    wait_drained();

    // Random settings, random frames; the last phase runs without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_random_setting();
      if (p == RANDOM_PHASES - 1) quiet_run = 1'b1;
      repeat (FRAMES_PER_PHASE) enqueue_frame(rand_frame());
      wait_drained();
    end

    if (mismatch_count == 0 && expected_mix.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
